>>> rtl/compacting_member_address_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the compacting member address table
// Property wrappers that fall away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_MEMBER_ADDRESS_TABLE_ASSERT_SVH
`define COMPACTING_MEMBER_ADDRESS_TABLE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CMAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CMAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CMAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CMAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/cmat_pkg.sv
// ----------------------------------------------------------------------------
// Compacting member address table package
// Payload types, operation and status codes, and the cell-to-cell link.
// ----------------------------------------------------------------------------
package cmat_pkg;

  localparam int SLOT_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int SLOT_IDX_W = 3;
  localparam int COUNT_W    = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [BYTE_W-1:0]     address_high;
    logic [BYTE_W-1:0]     address_low;
    logic [SLOT_IDX_W-1:0] slot_index;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_high;
    logic [BYTE_W-1:0]   read_low;
    logic [COUNT_W-1:0]  member_count;
    logic [STATUS_W-1:0] status;
  } result_t;

  // command broadcast to every cell while an item is in flight
  typedef struct packed {
    logic [SLOT_W-1:0]     addr;
    logic [SLOT_IDX_W-1:0] idx;
  } cmd_t;

  // tokens handed from one cell to the next: the operation token and,
  // in the cycle after it, the member count token
  typedef struct packed {
    logic                op_vld;
    logic [OP_W-1:0]     op;
    logic                done;
    logic                shift;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   data;
    logic                cnt_vld;
    logic                cnt_run;
    logic [COUNT_W-1:0]  cnt;
  } link_t;

endpackage

>>> rtl/cmat_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cmat_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/cmat_cell.sv
// ----------------------------------------------------------------------------
// Member table cell
// Holds one slot, acts on the tokens passing through and hands them right.
// ----------------------------------------------------------------------------
module cmat_cell
  import cmat_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  link_t             link_i,
  input  logic [SLOT_W-1:0] next_slot_i,
  output link_t             link_o,
  output logic [SLOT_W-1:0] slot_o
);

  // slot_index reaches this cell only when the cell number fits its width
  localparam bit                    IDX_REACH = (CELL_IDX < (1 << SLOT_IDX_W));
  localparam logic [SLOT_IDX_W-1:0] MY_IDX    = SLOT_IDX_W'(CELL_IDX);

  logic [SLOT_W-1:0] slot_q, slot_d;
  link_t             link_q, link_d;
  logic              idx_hit;
  logic              slot_empty;
  logic              slot_match;

  assign idx_hit    = IDX_REACH && (cmd_i.idx == MY_IDX);
  assign slot_empty = (slot_q == '0);
  assign slot_match = (slot_q == cmd_i.addr);

  // act on the tokens held by the left neighbor
  always_comb begin
    slot_d = slot_q;
    link_d = link_i;
    if (link_i.op_vld && !link_i.done) begin
      case (link_i.op)
        OP_INSERT: begin
          if (slot_empty) begin
            slot_d        = cmd_i.addr;
            link_d.done   = 1'b1;
            link_d.status = ST_DONE;
          end else if (slot_match) begin
            link_d.done   = 1'b1;
            link_d.status = ST_PRESENT;
          end
        end
        OP_REMOVE: begin
          // pull the right neighbor in from the first match onward
          if (link_i.shift || slot_match) begin
            slot_d       = next_slot_i;
            link_d.shift = 1'b1;
          end
        end
        OP_WRITE: begin
          if (idx_hit) begin
            slot_d = cmd_i.addr;
          end
        end
        OP_READ: begin
          if (idx_hit) begin
            link_d.data = slot_q;
          end
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
    // count leading members; stop at the first empty slot
    if (link_i.cnt_vld && link_i.cnt_run) begin
      if (slot_empty) begin
        link_d.cnt_run = 1'b0;
      end else if (link_i.cnt != COUNT_MAX) begin
        link_d.cnt = link_i.cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      link_q <= '0;
    end else begin
      slot_q <= slot_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;
  assign slot_o = slot_q;

endmodule

>>> rtl/compacting_member_address_table.sv
// ----------------------------------------------------------------------------
// Compacting member address table
// The operation token walks the row of cells one slot per cycle, count token
// behind it; the result is collected and moved into the output register.
// A new item is accepted only after the last result reached that register.
// Reset: all slots cleared to zero (empty), no item in flight.
// ----------------------------------------------------------------------------
`include "compacting_member_address_table_assert.svh"

module compacting_member_address_table
  import cmat_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmat_stream_if.sink   item_i,
  cmat_stream_if.source result_o
);

  link_t             links [TABLE_DEPTH+1];
  logic [SLOT_W-1:0] slots [TABLE_DEPTH+1];
  link_t             inj_q, inj_d;
  link_t             exit_link;
  cmd_t              cmd_q;
  item_t             item;
  logic [SLOT_W-1:0] item_addr;
  logic              item_xfer;
  logic              busy_q;
  logic              pend_q;
  logic              out_vld_q;
  logic              move;
  result_t           res_q;
  result_t           out_q;
  logic [STATUS_W-1:0] exit_status;

  assign item      = item_i.payload;
  assign item_addr = {item.address_high, item.address_low};
  assign item_i.ready = !busy_q;
  assign item_xfer = item_i.valid && !busy_q;

  // inject the operation token, then the count token in the cycle after
  always_comb begin
    inj_d = '0;
    if (item_xfer) begin
      inj_d.op_vld = 1'b1;
      inj_d.op     = item.operation;
      inj_d.status = ST_DONE;
      if (item_addr == '0) begin
        if (item.operation == OP_INSERT) begin
          inj_d.done   = 1'b1;
          inj_d.status = ST_DONE;
        end else if (item.operation == OP_REMOVE) begin
          inj_d.done   = 1'b1;
          inj_d.status = ST_ABSENT;
        end
      end
    end
    if (inj_q.op_vld) begin
      inj_d.cnt_vld = 1'b1;
      inj_d.cnt_run = 1'b1;
      inj_d.cnt     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q <= '0;
    end else begin
      inj_q <= inj_d;
    end
  end

  // hold the command for the cells while the item is in flight
  always_ff @(posedge clk_i) begin
    if (item_xfer) begin
      cmd_q.addr <= item_addr;
      cmd_q.idx  <= item.slot_index;
    end
  end

  assign links[0]           = inj_q;
  assign slots[TABLE_DEPTH] = '0;

  // row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cmat_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_q),
      .link_i     (links[i]),
      .next_slot_i(slots[i+1]),
      .link_o     (links[i+1]),
      .slot_o     (slots[i])
    );
  end

  assign exit_link = links[TABLE_DEPTH];

  // pass on a decided token's status, or resolve a token that left the row undecided
  always_comb begin
    if (exit_link.done) begin
      exit_status = exit_link.status;
    end else begin
      case (exit_link.op)
        OP_INSERT: exit_status = ST_FULL;
        OP_REMOVE: exit_status = exit_link.shift ? ST_DONE : ST_ABSENT;
        default:   exit_status = ST_DONE;
      endcase
    end
  end

  // collect the result from the tokens leaving the row
  always_ff @(posedge clk_i) begin
    if (exit_link.op_vld) begin
      res_q.read_high <= exit_link.data[SLOT_W-1:BYTE_W];
      res_q.read_low  <= exit_link.data[BYTE_W-1:0];
      res_q.status    <= exit_status;
    end
    if (exit_link.cnt_vld) begin
      res_q.member_count <= exit_link.cnt;
    end
  end

  assign move = pend_q && (!out_vld_q || result_o.ready);

  // advance the finished result into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (item_xfer) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (exit_link.cnt_vld) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= res_q;
    end
  end

  assign result_o.valid   = out_vld_q;
  assign result_o.payload = out_q;

  `CMAT_ASSERT_NXT(a_xfer_busy, clk_i, rst_ni, item_xfer, busy_q, "accepted item not in flight")
  `CMAT_ASSERT_IMP(a_exit_busy, clk_i, rst_ni, exit_link.op_vld, busy_q, "token left the row while idle")
  `CMAT_ASSERT_IMP(a_cnt_follows, clk_i, rst_ni, exit_link.cnt_vld, $past(exit_link.op_vld), "count token not one cycle behind")
  `CMAT_ASSERT_IMP(a_pend_busy, clk_i, rst_ni, pend_q, busy_q && !exit_link.op_vld, "pending result outside an item")

endmodule

>>> bench/cmat_member_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Member table checker
// Watches the item and result channels of the member address table. It keeps
// its own copy of the slot roster, works out the answer for every accepted
// item, and compares each accepted result with the oldest answer waiting.
// ----------------------------------------------------------------------------
module cmat_member_checker
  import cmat_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  logic    item_ready_i,
  input  item_t   item_i,
  input  logic    result_valid_i,
  input  logic    result_ready_i,
  input  result_t result_i,
  output int      mismatch_count_o,
  output int      pending_count_o
);

  localparam int PRINT_CAP = 40;

  logic [SLOT_W-1:0] roster [TABLE_DEPTH];
  result_t           answer_q [$];
  int                result_seq;

  // Print the first few mismatches, count all of them
  task automatic report_mismatch(input string msg);
    if (mismatch_count_o < PRINT_CAP) begin
      $display("[%0t] mismatch, result %0d: %s", $time, result_seq, msg);
    end
    mismatch_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
    end
  endtask

  // Number of leading occupied slots, saturated to the count field
  function automatic logic [COUNT_W-1:0] leading_members();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH && roster[i] != '0; i++) n++;
    return (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
  endfunction

  // Apply one item to the roster and return the answer it gives
  function automatic result_t apply_to_roster(input item_t it);
    result_t           ans;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] rd;
    int                hit;
    ans  = '0;
    rd   = '0;
    hit  = -1;
    addr = {it.address_high, it.address_low};
    ans.status = ST_DONE;
    case (it.operation)
      OP_INSERT: begin
        // first slot that is empty or equal decides; zero changes nothing
        if (addr != '0) begin
          for (int i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
            if (roster[i] == '0 || roster[i] == addr) hit = i;
          end
          if (hit < 0) begin
            ans.status = ST_FULL;
          end else if (roster[hit] == addr) begin
            ans.status = ST_PRESENT;
          end else begin
            roster[hit] = addr;
          end
        end
      end
      OP_REMOVE: begin
        // zero is never a member; otherwise drop the first match and close up
        if (addr != '0) begin
          for (int i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
            if (roster[i] == addr) hit = i;
          end
        end
        if (hit < 0) begin
          ans.status = ST_ABSENT;
        end else begin
          for (int j = hit; j + 1 < TABLE_DEPTH; j++) roster[j] = roster[j + 1];
          roster[TABLE_DEPTH - 1] = '0;
        end
      end
      OP_WRITE: begin
        if (it.slot_index < TABLE_DEPTH) roster[it.slot_index] = addr;
      end
      default: begin
        if (it.slot_index < TABLE_DEPTH) rd = roster[it.slot_index];
      end
    endcase
    ans.read_high    = rd[SLOT_W-1:BYTE_W];
    ans.read_low     = rd[BYTE_W-1:0];
    ans.member_count = leading_members();
    return ans;
  endfunction

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
    result_seq       = 0;
  end

  // Retire results first, then queue the answer for a newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) roster[i] = '0;
      answer_q.delete();
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = answer_q.pop_front();
          check_field("read_high", result_i.read_high, want.read_high);
          check_field("read_low", result_i.read_low, want.read_low);
          check_field("member_count", result_i.member_count, want.member_count);
          check_field("status", result_i.status, want.status);
        end
        result_seq++;
      end
      if (item_valid_i && item_ready_i) begin
        answer_q.push_back(apply_to_roster(item_i));
      end
    end
    pending_count_o = answer_q.size();
  end

endmodule

>>> bench/tb_compacting_member_address_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Member address table testbench
// Drives insert, remove, slot write and slot read items into the table with
// random gaps and result stalls; a checker beside the block predicts and
// compares every result. Directed corner items come first, then random ones.
// ----------------------------------------------------------------------------
module tb_compacting_member_address_table;
  import cmat_pkg::*;

  localparam int TABLE_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 1930;
  localparam int POOL_SIZE    = 12;
  localparam int IDLE_PCT     = 27;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 3 + 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   cycle_count;
  int   mismatch_count;
  int   pending_count;
  int   op_seen [4];

  logic [SLOT_W-1:0] address_pool [POOL_SIZE];

  cmat_stream_if #(.T(item_t))   item_if ();
  cmat_stream_if #(.T(result_t)) result_if ();

  compacting_member_address_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  cmat_member_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_if.valid),
    .item_ready_i     (item_if.ready),
    .item_i           (item_if.payload),
    .result_valid_i   (result_if.valid),
    .result_ready_i   (result_if.ready),
    .result_i         (result_if.payload),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_compacting_member_address_table: errors");
      $finish;
    end
  end

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk_i) begin
    result_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic item_t make_item(input logic [OP_W-1:0] op,
                                      input logic [SLOT_W-1:0] addr,
                                      input logic [SLOT_IDX_W-1:0] idx);
    item_t it;
    it.operation    = op;
    it.address_high = addr[SLOT_W-1:BYTE_W];
    it.address_low  = addr[BYTE_W-1:0];
    it.slot_index   = idx;
    return it;
  endfunction

  // Mostly addresses from a small pool so that duplicates and hits are common
  function automatic logic [SLOT_W-1:0] pick_address();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 20) return SLOT_W'($urandom);
    return address_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic item_t random_item();
    int                roll;
    logic [SLOT_W-1:0] addr;
    logic [OP_W-1:0]   op;
    roll = $urandom_range(99);
    addr = pick_address();
    if (roll < 35) begin
      op = OP_INSERT;
    end else if (roll < 65) begin
      op = OP_REMOVE;
    end else if (roll < 75) begin
      op = OP_WRITE;
      if ($urandom_range(3) == 0) addr = '0;
    end else begin
      op = OP_READ;
    end
    return make_item(op, addr, SLOT_IDX_W'($urandom_range(TABLE_DEPTH - 1)));
  endfunction

  // Idle at random, then hold the item until it transfers
  task automatic send_item(input item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    @(negedge clk_i);
    while (!item_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    op_seen[it.operation]++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    calm            = 1'b0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    result_if.ready = 1'b0;
    for (int k = 0; k < 4; k++) op_seen[k] = 0;
    address_pool[0] = 16'hFFFF;
    address_pool[1] = 16'h0001;
    address_pool[2] = 16'h8000;
    for (int k = 3; k < POOL_SIZE; k++) begin
      address_pool[k] = SLOT_W'($urandom_range(16'hFFFF, 1));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, zero address, absent remove
    send_item(make_item(OP_READ,   16'h0000, 3'd0));
    send_item(make_item(OP_INSERT, 16'h0000, 3'd0));
    send_item(make_item(OP_REMOVE, 16'h0000, 3'd0));
    send_item(make_item(OP_REMOVE, 16'h1234, 3'd0));
    // fill to capacity, with a duplicate on the way
    send_item(make_item(OP_INSERT, 16'hFFFF, 3'd7));
    send_item(make_item(OP_INSERT, 16'hFFFF, 3'd0));
    send_item(make_item(OP_INSERT, 16'h0001, 3'd0));
    send_item(make_item(OP_INSERT, 16'h8000, 3'd0));
    send_item(make_item(OP_INSERT, 16'h00FF, 3'd0));
    send_item(make_item(OP_INSERT, 16'hFF00, 3'd0));
    send_item(make_item(OP_INSERT, 16'h1234, 3'd0));
    send_item(make_item(OP_INSERT, 16'h5A5A, 3'd0));
    send_item(make_item(OP_INSERT, 16'hA5A5, 3'd0));
    // full table: new address refused, existing one still reported present
    send_item(make_item(OP_INSERT, 16'h7777, 3'd0));
    send_item(make_item(OP_INSERT, 16'hFFFF, 3'd0));
    send_item(make_item(OP_READ,   16'h0000, 3'd7));
    // remove first and last entries
    send_item(make_item(OP_REMOVE, 16'hFFFF, 3'd0));
    send_item(make_item(OP_REMOVE, 16'hA5A5, 3'd0));
    // punch a hole; insert of a later duplicate lands in the hole
    send_item(make_item(OP_WRITE,  16'h0000, 3'd2));
    send_item(make_item(OP_INSERT, 16'h5A5A, 3'd0));
    send_item(make_item(OP_READ,   16'h0000, 3'd2));
    send_item(make_item(OP_REMOVE, 16'h5A5A, 3'd0));
    send_item(make_item(OP_WRITE,  16'hFFFF, 3'd7));
    send_item(make_item(OP_READ,   16'h0000, 3'd7));
    wait_drained();

    // random mix with a calm stretch and periodic drains
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      if (n % 400 == 399) wait_drained();
      if (n % 250 == 249) begin
        address_pool[$urandom_range(POOL_SIZE - 1)] = SLOT_W'($urandom_range(16'hFFFF, 1));
      end
      send_item(random_item());
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d inserts, %0d removes, %0d slot writes, %0d slot reads",
             op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_WRITE], op_seen[OP_READ]);
    $display("mismatches found: %0d, results still outstanding: %0d",
             mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_compacting_member_address_table: clean");
    end else begin
      $display("tb_compacting_member_address_table: errors");
    end
    $finish;
  end

endmodule
